FILE: rtl/core/assert_macros.svh
// Assertion helpers. Every user module has clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on each rising clock edge outside reset.
`define UFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be true outside reset.
`define UFD_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

FILE: rtl/core/ufd_pkg.sv
package ufd_pkg;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_STRAY    = 3'd1,
      ST_BAD_LEAD = 3'd2,
      ST_BAD_CONT = 3'd3,
      ST_TRUNC    = 3'd4,
      ST_RANGE    = 3'd5
   } status_type;

   // What the back end has to do for one queued entry.
   typedef enum logic [1:0] {
      K_UNIT  = 2'd0,
      K_PAIR  = 2'd1,
      K_ERROR = 2'd2
   } kind_type;

   localparam int CP_W = 21;

   typedef struct packed {
      kind_type         kind;
      logic [CP_W-1:0]  value;
      status_type       status;
      logic             eot;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   localparam logic [7:0] LEAD2_MIN  = 8'h80;
   localparam logic [7:0] LEAD2_LOW  = 8'hc0;
   localparam logic [7:0] LEAD3_LOW  = 8'he0;
   localparam logic [7:0] LEAD4_LOW  = 8'hf0;
   localparam logic [7:0] LEAD_LIMIT = 8'hf8;
   localparam logic [1:0] CONT_TAG   = 2'b10;

   localparam logic [CP_W-1:0] BMP_LIMIT     = 21'h010000;
   localparam logic [CP_W-1:0] UNICODE_LIMIT = 21'h110000;
   localparam logic [15:0]     HIGH_SURR     = 16'hd800;
   localparam logic [15:0]     LOW_SURR      = 16'hdc00;

endpackage

FILE: rtl/core/ufd_req_if.sv
interface ufd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_text;

   modport source (output valid, in_byte, end_of_text, input ready);
   modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

FILE: rtl/core/ufd_rsp_if.sv
interface ufd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic [2:0]  status;
   logic        last_of_run;
   logic        text_done;

   modport source (output valid, code_unit, status, last_of_run, text_done, input ready);
   modport sink (input valid, code_unit, status, last_of_run, text_done, output ready);
endinterface

FILE: rtl/core/ufd_front.sv
module ufd_front (
   input  logic                     clock,
   input  logic                     reset,
   ufd_req_if.sink                  req_ch,
   input  ufd_pkg::fifo_status_type q_stat,
   output logic                     push,
   output ufd_pkg::entry_type       push_entry
);
   `include "assert_macros.svh"

   logic [ufd_pkg::CP_W-1:0] acc_ff, acc_in;
   logic [1:0]               rem_ff, rem_in;
   logic                     disc_ff, disc_in;

   logic                     fire;
   logic                     fail;
   ufd_pkg::status_type      fail_st;
   logic [7:0]               b;
   logic                     eot;
   logic [ufd_pkg::CP_W-1:0] cp_next;
   logic [1:0]               rem_dec;

   assign req_ch.ready = !q_stat.full;
   assign fire = req_ch.valid && req_ch.ready;
   assign b    = req_ch.in_byte;
   assign eot  = req_ch.end_of_text;
   assign cp_next = {acc_ff[ufd_pkg::CP_W-7:0], b[5:0]};
   assign rem_dec = rem_ff - 2'd1;

   always_comb begin
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      disc_in = disc_ff;
      fail    = 1'b0;
      fail_st = ufd_pkg::ST_OK;
      push    = 1'b0;
      push_entry = '{kind: ufd_pkg::K_UNIT, value: '0, status: ufd_pkg::ST_OK, eot: eot};
      if (fire) begin
         if (disc_ff) begin
            if (eot) begin
               disc_in = 1'b0;
            end
         end else if (rem_ff == 2'd0) begin
            if (b < ufd_pkg::LEAD2_MIN) begin
               push = 1'b1;
               push_entry.value = {{(ufd_pkg::CP_W-8){1'b0}}, b};
            end else if (b < ufd_pkg::LEAD2_LOW) begin
               fail    = 1'b1;
               fail_st = ufd_pkg::ST_STRAY;
            end else if (b < ufd_pkg::LEAD_LIMIT) begin
               if (b < ufd_pkg::LEAD3_LOW) begin
                  acc_in = {{(ufd_pkg::CP_W-5){1'b0}}, b[4:0]};
                  rem_in = 2'd1;
               end else if (b < ufd_pkg::LEAD4_LOW) begin
                  acc_in = {{(ufd_pkg::CP_W-4){1'b0}}, b[3:0]};
                  rem_in = 2'd2;
               end else begin
                  acc_in = {{(ufd_pkg::CP_W-3){1'b0}}, b[2:0]};
                  rem_in = 2'd3;
               end
               if (eot) begin
                  fail    = 1'b1;
                  fail_st = ufd_pkg::ST_TRUNC;
               end
            end else begin
               fail    = 1'b1;
               fail_st = ufd_pkg::ST_BAD_LEAD;
            end
         end else if (b[7:6] != ufd_pkg::CONT_TAG) begin
            fail    = 1'b1;
            fail_st = ufd_pkg::ST_BAD_CONT;
         end else begin
            acc_in = cp_next;
            rem_in = rem_dec;
            if (rem_dec == 2'd0) begin
               acc_in = '0;
               if (cp_next < ufd_pkg::BMP_LIMIT) begin
                  push = 1'b1;
                  push_entry.value = cp_next;
               end else if (cp_next < ufd_pkg::UNICODE_LIMIT) begin
                  push = 1'b1;
                  push_entry.kind  = ufd_pkg::K_PAIR;
                  push_entry.value = cp_next;
               end else begin
                  fail    = 1'b1;
                  fail_st = ufd_pkg::ST_RANGE;
               end
            end else if (eot) begin
               fail    = 1'b1;
               fail_st = ufd_pkg::ST_TRUNC;
            end
         end
         if (fail) begin
            acc_in  = '0;
            rem_in  = 2'd0;
            disc_in = !eot;
            push    = 1'b1;
            push_entry = '{kind: ufd_pkg::K_ERROR, value: '0, status: fail_st, eot: eot};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         rem_ff  <= 2'd0;
         disc_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         disc_ff <= disc_in;
      end
   end

   // while dropping bytes no sequence can be open
   `UFD_NEVER(a_disc_no_open_seq, disc_ff && (rem_ff != 2'd0), "open sequence while discarding")
endmodule

FILE: rtl/core/ufd_fifo.sv
module ufd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ufd_pkg::entry_type       push_entry,
   input  logic                     pop,
   output ufd_pkg::entry_type       head,
   output ufd_pkg::fifo_status_type stat
);
   `include "assert_macros.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ufd_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

   `UFD_NEVER(a_fifo_overflow, push && stat.full && !pop, "queue overflow")
   `UFD_NEVER(a_fifo_underflow, pop && stat.empty, "queue underflow")
endmodule

FILE: rtl/core/ufd_back.sv
module ufd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ufd_pkg::entry_type       head,
   input  ufd_pkg::fifo_status_type q_stat,
   output logic                     pop,
   ufd_rsp_if.source                rsp_ch
);
   `include "assert_macros.svh"

   logic        valid_ff, valid_in;
   logic [15:0] unit_ff, unit_in;
   logic [2:0]  status_ff, status_in;
   logic        last_ff, last_in;
   logic        done_ff, done_in;
   logic        half_ff, half_in;   // high surrogate already sent

   logic        load;
   logic [19:0] sv;

   assign load = !valid_ff || rsp_ch.ready;
   assign sv   = 20'(head.value - ufd_pkg::BMP_LIMIT);

   always_comb begin
      valid_in  = valid_ff;
      unit_in   = unit_ff;
      status_in = status_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      half_in   = half_ff;
      pop       = 1'b0;
      if (load) begin
         valid_in = !q_stat.empty;
         if (!q_stat.empty) begin
            status_in = head.status;
            last_in   = 1'b1;
            done_in   = head.eot;
            pop       = 1'b1;
            case (head.kind)
               ufd_pkg::K_UNIT: begin
                  unit_in = head.value[15:0];
               end
               ufd_pkg::K_PAIR: begin
                  if (!half_ff) begin
                     unit_in = ufd_pkg::HIGH_SURR | {6'd0, sv[19:10]};
                     last_in = 1'b0;
                     done_in = 1'b0;
                     pop     = 1'b0;
                     half_in = 1'b1;
                  end else begin
                     unit_in = ufd_pkg::LOW_SURR | {6'd0, sv[9:0]};
                     half_in = 1'b0;
                  end
               end
               default: begin
                  unit_in = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff   <= unit_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      done_ff   <= done_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.code_unit   = unit_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.last_of_run = last_ff;
   assign rsp_ch.text_done   = done_ff;

   // the pair entry stays queued until its low half goes out
   `UFD_ASSERT(a_pair_held, half_ff |-> (!q_stat.empty && head.kind == ufd_pkg::K_PAIR), "pair entry lost")
endmodule

FILE: rtl/core/utf8_to_utf16_decoder_unit.sv
// UTF-8 to UTF-16 transcoder.
// req_ch carries one UTF-8 byte per transfer plus end_of_text on the last
// byte of a string. rsp_ch carries UTF-16 code units with a status code,
// last_of_run on the final result of a byte and text_done on the result
// that closes a string. Bytes that only extend a sequence give no result;
// a code point from 0x10000 to 0x10FFFF gives a high then a low surrogate.
// After an error one error result is sent and bytes are dropped up to and
// including the end-of-text byte.
// A result reaches rsp_ch through the queue, which the decode writes, and
// then the output register.
// Throughput: one byte per cycle while the queue is not full; a surrogate
// pair holds the queue head until its low half enters the output register.
// req_ch.ready drops only when the QUEUE_DEPTH-entry queue is full.
// When rsp_ch stalls, the output register holds its result and the queue
// fills; then req_ch stalls too. Nothing is lost.
// Reset clears the decode state, the queue and the output valid.
module utf8_to_utf16_decoder_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   ufd_req_if.sink     req_ch,
   ufd_rsp_if.source   rsp_ch
);

   logic                     push, pop;
   ufd_pkg::entry_type       push_entry, head;
   ufd_pkg::fifo_status_type q_stat;

   ufd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   ufd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (q_stat)
   );

   ufd_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: dv/tb_utf8_to_utf16_decoder_unit.sv
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_unit;

   localparam int TOTAL_BYTES = 450;
   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 12;

   typedef struct packed {
      logic [15:0]         code_unit;
      ufd_pkg::status_type status;
      logic                last_of_run;
      logic                text_done;
   } utf16_rsp_type;

   typedef struct {
      logic [7:0]    in_byte;
      logic          eot;
      logic          typed;
      utf16_rsp_type want;
   } text_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ufd_req_if req_ch ();
   ufd_rsp_if rsp_ch ();

   utf8_to_utf16_decoder_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // decoder state mirror
   logic [20:0] dec_acc;
   logic [1:0]  dec_left;
   logic        dec_dropping;

   utf16_rsp_type units_due[$];
   utf16_rsp_type decoded_now[$];
   text_row_type  directed_rows[$];
   logic [7:0]    text_bytes[$];

   int idle_pct = 10;
   int fail_count = 0;
   int bytes_sent = 0;
   int bytes_decoded = 0;
   int units_checked = 0;
   int pairs_seen = 0;
   int errors_seen = 0;
   int stall_cycles = 0;

   function automatic void push_error(ufd_pkg::status_type st, logic eot);
      dec_acc      = '0;
      dec_left     = '0;
      dec_dropping = !eot;
      decoded_now.insert(decoded_now.size(), '{16'h0000, st, 1'b1, eot});
   endfunction

   function automatic void push_point(logic [20:0] cp, logic eot);
      logic [20:0] offs;
      dec_acc = '0;
      if (cp < ufd_pkg::BMP_LIMIT) begin
         decoded_now.insert(decoded_now.size(), '{cp[15:0], ufd_pkg::ST_OK, 1'b1, eot});
      end else if (cp < ufd_pkg::UNICODE_LIMIT) begin
         offs = cp - ufd_pkg::BMP_LIMIT;
         decoded_now.insert(decoded_now.size(),
                            '{ufd_pkg::HIGH_SURR | {6'b0, offs[19:10]}, ufd_pkg::ST_OK,
                              1'b0, 1'b0});
         decoded_now.insert(decoded_now.size(),
                            '{ufd_pkg::LOW_SURR | {6'b0, offs[9:0]}, ufd_pkg::ST_OK,
                              1'b1, eot});
      end else begin
         push_error(ufd_pkg::ST_RANGE, eot);
      end
   endfunction

   // Advances the mirrored state by one byte; results land in decoded_now.
   function automatic void decode_byte(logic [7:0] b, logic eot);
      decoded_now.delete();
      if (dec_dropping) begin
         if (eot) dec_dropping = 1'b0;
         return;
      end
      if (dec_left == 2'd0) begin
         if (b < 8'h80) begin
            push_point({13'b0, b}, eot);
         end else if (b < 8'hc0) begin
            push_error(ufd_pkg::ST_STRAY, eot);
         end else begin
            if (b < 8'he0) begin
               dec_acc  = {16'b0, b[4:0]};
               dec_left = 2'd1;
            end else if (b < 8'hf0) begin
               dec_acc  = {17'b0, b[3:0]};
               dec_left = 2'd2;
            end else if (b < 8'hf8) begin
               dec_acc  = {18'b0, b[2:0]};
               dec_left = 2'd3;
            end else begin
               push_error(ufd_pkg::ST_BAD_LEAD, eot);
               return;
            end
            if (eot) push_error(ufd_pkg::ST_TRUNC, eot);
         end
      end else if (b[7:6] != 2'b10) begin
         push_error(ufd_pkg::ST_BAD_CONT, eot);
      end else begin
         dec_acc  = {dec_acc[14:0], b[5:0]};
         dec_left = dec_left - 2'd1;
         if (dec_left == 2'd0) push_point(dec_acc, eot);
         else if (eot) push_error(ufd_pkg::ST_TRUNC, eot);
      end
   endfunction

   function automatic void add_row(logic [7:0] b, logic eot);
      directed_rows.insert(directed_rows.size(), '{b, eot, 1'b0, '0});
   endfunction

   function automatic void add_typed(logic [7:0] b, logic eot, logic [15:0] unit,
                                     ufd_pkg::status_type st, logic last, logic done);
      directed_rows.insert(directed_rows.size(), '{b, eot, 1'b1, '{unit, st, last, done}});
   endfunction

   function automatic logic [20:0] pick_in(int unsigned lo, int unsigned hi);
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return lo[20:0];
      if (r == 1) return hi[20:0];
      return 21'($urandom_range(lo, hi));
   endfunction

   function automatic logic [20:0] pick_point(int len);
      case (len)
         1:       return pick_in(32'h0, 32'h7f);
         2:       return pick_in(32'h80, 32'h7ff);
         3:       return pick_in(32'h800, 32'hffff);
         default: return pick_in(32'h10000, 32'h10ffff);
      endcase
   endfunction

   function automatic void encode_point(logic [20:0] cp, int len);
      case (len)
         1: text_bytes.insert(text_bytes.size(), {1'b0, cp[6:0]});
         2: begin
            text_bytes.insert(text_bytes.size(), {3'b110, cp[10:6]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
         end
         3: begin
            text_bytes.insert(text_bytes.size(), {4'b1110, cp[15:12]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[11:6]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
         end
         default: begin
            text_bytes.insert(text_bytes.size(), {5'b11110, cp[20:18]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[17:12]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[11:6]});
            text_bytes.insert(text_bytes.size(), {2'b10, cp[5:0]});
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
                            input utf16_rsp_type want);
      logic was_dropping;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.in_byte     <= b;
      req_ch.end_of_text <= eot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      was_dropping = dec_dropping;
      decode_byte(b, eot);
      if (typed) units_due.insert(units_due.size(), want);
      else foreach (decoded_now[k]) units_due.insert(units_due.size(), decoded_now[k]);
      bytes_sent++;
      if (!was_dropping) bytes_decoded++;
      @(negedge clock);
   endtask

   // One string: mostly well-formed characters, with errors mixed in.
   task automatic send_random_text();
      int n_chars;
      int r;
      int len;
      int start;
      int pos;
      logic [7:0] junk;
      text_bytes.delete();
      n_chars = $urandom_range(1, 6);
      for (int i = 0; i < n_chars; i++) begin
         r     = $urandom_range(0, 99);
         start = text_bytes.size();
         if (r < 30) begin
            encode_point(pick_point(1), 1);
         end else if (r < 48) begin
            encode_point(pick_point(2), 2);
         end else if (r < 66) begin
            encode_point(pick_point(3), 3);
         end else if (r < 80) begin
            encode_point(pick_point(4), 4);
         end else if (r < 84) begin
            text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'h80, 8'hbf)));
         end else if (r < 87) begin
            text_bytes.insert(text_bytes.size(), 8'($urandom_range(8'hf8, 8'hff)));
         end else if (r < 90) begin
            encode_point(pick_in(32'h110000, 32'h1fffff), 4);
         end else if (r < 94) begin
            // a continuation slot holds a byte without the 10 tag
            len = $urandom_range(2, 4);
            encode_point(pick_point(len), len);
            pos  = $urandom_range(start + 1, start + len - 1);
            junk = 8'($urandom_range(0, 255));
            if (junk[7:6] == 2'b10) junk[6] = 1'b1;
            text_bytes[pos] = junk;
         end else if (r < 97) begin
            // string ends inside a sequence
            len = $urandom_range(2, 4);
            encode_point(pick_point(len), len);
            pos = start + $urandom_range(1, len - 1);
            while (text_bytes.size() > pos) void'(text_bytes.pop_back());
            break;
         end else begin
            text_bytes.insert(text_bytes.size(), 8'($urandom_range(0, 255)));
         end
      end
      foreach (text_bytes[k]) send_byte(text_bytes[k], k == text_bytes.size() - 1, 1'b0, '0);
   endtask

   // response sink
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin
      utf16_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (units_due.size() == 0) begin
            $error("unexpected result: code_unit %h status %0d", rsp_ch.code_unit,
                   rsp_ch.status);
            fail_count++;
         end else begin
            want = units_due.pop_front();
            units_checked++;
            if (want.status != ufd_pkg::ST_OK) errors_seen++;
            else if (!want.last_of_run) pairs_seen++;
            if (rsp_ch.code_unit !== want.code_unit) begin
               $error("code_unit: expected %h, got %h", want.code_unit, rsp_ch.code_unit);
               fail_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %b, got %b", want.last_of_run,
                      rsp_ch.last_of_run);
               fail_count++;
            end
            if (rsp_ch.text_done !== want.text_done) begin
               $error("text_done: expected %b, got %b", want.text_done, rsp_ch.text_done);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results pending",
                  stall_cycles, units_due.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.in_byte     = 8'h00;
      req_ch.end_of_text = 1'b0;
      dec_acc            = '0;
      dec_left           = '0;
      dec_dropping       = 1'b0;

      add_typed(8'h00, 1'b0, 16'h0000, ufd_pkg::ST_OK, 1'b1, 1'b0);
      add_typed(8'h7f, 1'b1, 16'h007f, ufd_pkg::ST_OK, 1'b1, 1'b1);
      add_typed(8'h80, 1'b1, 16'h0000, ufd_pkg::ST_STRAY, 1'b1, 1'b1);
      // bad lead mid-string: the rest of the string is dropped
      add_typed(8'hff, 1'b0, 16'h0000, ufd_pkg::ST_BAD_LEAD, 1'b1, 1'b0);
      add_row(8'h41, 1'b0);
      add_row(8'hc3, 1'b1);
      add_typed(8'hf8, 1'b1, 16'h0000, ufd_pkg::ST_BAD_LEAD, 1'b1, 1'b1);
      add_row(8'hc2, 1'b0);
      add_row(8'h80, 1'b1);
      add_row(8'he2, 1'b0);
      add_row(8'h82, 1'b0);
      add_row(8'hac, 1'b1);
      // U+10FFFF, the top surrogate pair
      add_row(8'hf4, 1'b0);
      add_row(8'h8f, 1'b0);
      add_row(8'hbf, 1'b0);
      add_row(8'hbf, 1'b1);
      add_row(8'hf4, 1'b0);
      add_row(8'h90, 1'b0);
      add_row(8'h80, 1'b0);
      add_typed(8'h80, 1'b1, 16'h0000, ufd_pkg::ST_RANGE, 1'b1, 1'b1);
      add_typed(8'he0, 1'b1, 16'h0000, ufd_pkg::ST_TRUNC, 1'b1, 1'b1);
      add_row(8'hc2, 1'b0);
      add_typed(8'h41, 1'b1, 16'h0000, ufd_pkg::ST_BAD_CONT, 1'b1, 1'b1);
      add_row(8'he2, 1'b0);
      add_typed(8'h82, 1'b1, 16'h0000, ufd_pkg::ST_TRUNC, 1'b1, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].in_byte, directed_rows[i].eot, directed_rows[i].typed,
                   directed_rows[i].want);

      while (bytes_sent < TOTAL_BYTES) begin
         // a long stretch with both sides streaming back to back
         idle_pct = (bytes_sent >= 150 && bytes_sent < 250) ? 0 : 10;
         send_random_text();
      end
      idle_pct = 10;
      req_ch.valid <= 1'b0;

      while (units_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d bytes (%0d decoded, rest dropped after errors)", bytes_sent,
               bytes_decoded);
      $display("Checked %0d results: %0d surrogate pairs, %0d error results",
               units_checked, pairs_seen, errors_seen);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ufd_pkg.sv
rtl/core/ufd_req_if.sv
rtl/core/ufd_rsp_if.sv
rtl/core/ufd_front.sv
rtl/core/ufd_fifo.sv
rtl/core/ufd_back.sv
rtl/core/utf8_to_utf16_decoder_unit.sv
dv/tb_utf8_to_utf16_decoder_unit.sv
